### sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fspa_pkg.sv
// Constants, codes and types of the fixed slot pool allocator
`default_nettype none
package fspa_pkg;

  localparam int INITIAL_SLOTS = 64;
  localparam int GROWTH        = 2;
  localparam int MAX_CHUNKS    = 16;
  localparam int FREE_DEPTH    = 256;

  localparam int CHUNK_W  = 4;
  localparam int SLOT_W   = 7;
  localparam int OFFSET_W = 23;
  localparam int ESIZE_W  = 16;
  localparam int HANDLE_W = CHUNK_W + SLOT_W;

  localparam int CHUNK_CAP0  = INITIAL_SLOTS;
  localparam int CHUNK_CAPN  = INITIAL_SLOTS * GROWTH;
  localparam int CURSOR_W    = $clog2(CHUNK_CAPN + 1);
  localparam int CHUNK_NUM_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int STACK_AW    = $clog2(FREE_DEPTH);
  localparam int STACK_CW    = $clog2(FREE_DEPTH + 1);

  localparam logic [ESIZE_W-1:0] ESIZE_RESET = ESIZE_W'(1);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_CHUNK   = 2'd1,
    ST_STORE_FULL = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [CHUNK_W-1:0]  chunk;
    logic [SLOT_W-1:0]   slot;
  } core_rsp_t;

  typedef struct packed {
    logic      valid;
    core_rsp_t rsp;
  } core_out_t;

  typedef struct packed {
    core_rsp_t           base;
    logic [OFFSET_W-1:0] byte_offset;
  } rsp_t;

endpackage
`default_nettype wire

### sv/fspa_req_if.sv
// Request channel: valid/ready with opcode and returned handle
`default_nettype none
interface fspa_req_if import fspa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [CHUNK_W-1:0] free_chunk;
  logic [SLOT_W-1:0]  free_slot;

  modport source (output valid, output opcode, output free_chunk, output free_slot,
                  input ready);
  modport sink   (input valid, input opcode, input free_chunk, input free_slot,
                  output ready);
endinterface
`default_nettype wire

### sv/fspa_rsp_if.sv
// Result channel: valid/ready with status, chunk, slot and byte offset
`default_nettype none
interface fspa_rsp_if import fspa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [CHUNK_W-1:0]  chunk;
  logic [SLOT_W-1:0]   slot;
  logic [OFFSET_W-1:0] byte_offset;

  modport source (output valid, output status, output chunk, output slot,
                  output byte_offset, input ready);
  modport sink   (input valid, input status, input chunk, input slot,
                  input byte_offset, output ready);
endinterface
`default_nettype wire

### sv/fspa_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module fspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### sv/fspa_core.sv
// Allocator state: free-list head, LIFO store behind it, chunk and cursor
`default_nettype none
module fspa_core import fspa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fspa_req_if.sink   in_req,
  input  wire logic  out_room,
  output core_out_t  core_out
);

  logic [CHUNK_NUM_W-1:0] chunk_number_r, chunk_number_nxt;
  logic [CURSOR_W-1:0]    cursor_r, cursor_nxt;
  logic                   head_valid_r, head_valid_nxt;
  logic [HANDLE_W-1:0]    head_handle_r, head_handle_nxt;
  logic [STACK_CW-1:0]    stack_count_r, stack_count_nxt;
  logic                   fwd_valid_r;
  logic [HANDLE_W-1:0]    fwd_data_r;

  logic                   accept;
  logic                   push;
  logic [HANDLE_W-1:0]    handle;
  logic [HANDLE_W-1:0]    ram_rdata;
  logic [HANDLE_W-1:0]    top_handle;
  logic [STACK_AW-1:0]    rd_addr;
  logic                   chunk_full;
  logic                   last_chunk;
  logic                   store_full;
  core_rsp_t              rsp;

  assign in_req.ready = out_room;
  assign accept       = in_req.valid & out_room;
  assign handle       = {in_req.free_chunk, in_req.free_slot};

  // read-during-write on the top entry is served from the bypass register
  assign top_handle = fwd_valid_r ? fwd_data_r : ram_rdata;

  assign chunk_full = (chunk_number_r == '0) ? (cursor_r >= CURSOR_W'(CHUNK_CAP0))
                                             : (cursor_r >= CURSOR_W'(CHUNK_CAPN));
  assign last_chunk = (chunk_number_r == CHUNK_NUM_W'(MAX_CHUNKS - 1));
  assign store_full = (stack_count_r == STACK_CW'(FREE_DEPTH));

  always_comb begin
    chunk_number_nxt = chunk_number_r;
    cursor_nxt       = cursor_r;
    head_valid_nxt   = head_valid_r;
    head_handle_nxt  = head_handle_r;
    stack_count_nxt  = stack_count_r;
    push             = 1'b0;
    rsp.status       = ST_OK;
    rsp.chunk        = '0;
    rsp.slot         = '0;
    if (accept) begin
      if (opcode_t'(in_req.opcode) == OP_FREE) begin
        priority if (!head_valid_r) begin
          head_handle_nxt = handle;
          head_valid_nxt  = 1'b1;
        end else if (!store_full) begin
          push            = 1'b1;
          stack_count_nxt = stack_count_r + 1'b1;
        end else begin
          rsp.status = ST_STORE_FULL;
        end
      end else if (head_valid_r) begin
        rsp.chunk = head_handle_r[HANDLE_W-1:SLOT_W];
        rsp.slot  = head_handle_r[SLOT_W-1:0];
        if (stack_count_r != '0) begin
          stack_count_nxt = stack_count_r - 1'b1;
          head_handle_nxt = top_handle;
        end else begin
          head_valid_nxt = 1'b0;
        end
      end else if (chunk_full) begin
        if (last_chunk) begin
          rsp.status = ST_NO_CHUNK;
        end else begin
          chunk_number_nxt = chunk_number_r + 1'b1;
          cursor_nxt       = CURSOR_W'(1);
          rsp.chunk        = CHUNK_W'(chunk_number_r + 1'b1);
        end
      end else begin
        rsp.chunk  = CHUNK_W'(chunk_number_r);
        rsp.slot   = SLOT_W'(cursor_r);
        cursor_nxt = cursor_r + 1'b1;
      end
    end
  end

  // keep the entry just below the next top count prefetched
  assign rd_addr = STACK_AW'(stack_count_nxt - 1'b1);

  fspa_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (FREE_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (STACK_AW'(stack_count_r)),
    .wr_data (handle),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_number_r <= '0;
      cursor_r       <= '0;
      head_valid_r   <= 1'b0;
      head_handle_r  <= '0;
      stack_count_r  <= '0;
      fwd_valid_r    <= 1'b0;
    end else begin
      chunk_number_r <= chunk_number_nxt;
      cursor_r       <= cursor_nxt;
      head_valid_r   <= head_valid_nxt;
      head_handle_r  <= head_handle_nxt;
      stack_count_r  <= stack_count_nxt;
      fwd_valid_r    <= push;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= handle;
  end

  assign core_out.valid = accept;
  assign core_out.rsp   = rsp;

endmodule
`default_nettype wire

### sv/fspa_out.sv
// Element size register, byte offset multiply and two-entry result buffer
`default_nettype none
module fspa_out import fspa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [ESIZE_W-1:0] cfg_wr_data,
  input  wire core_out_t          core_out,
  output logic                    out_room,
  fspa_rsp_if.source              out_rsp
);

  logic [ESIZE_W-1:0] esize_r;
  rsp_t               buf_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               push;
  logic               pop;
  rsp_t               wr_item;
  rsp_t               rd_item;

  assign wr_item.base        = core_out.rsp;
  assign wr_item.byte_offset = OFFSET_W'(core_out.rsp.slot) * OFFSET_W'(esize_r);

  assign push = core_out.valid;
  assign pop  = out_rsp.valid & out_rsp.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esize_r  <= ESIZE_RESET;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        esize_r <= cfg_wr_data;
      end
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item = buf_r[rd_ptr_r];

  assign out_room            = (cnt_r != 2'd2);
  assign out_rsp.valid       = (cnt_r != 2'd0);
  assign out_rsp.status      = rd_item.base.status;
  assign out_rsp.chunk       = rd_item.base.chunk;
  assign out_rsp.slot        = rd_item.base.slot;
  assign out_rsp.byte_offset = rd_item.byte_offset;

endmodule
`default_nettype wire

### sv/fixed_slot_pool_allocator.sv
// Top level of the fixed slot pool allocator
//
// in_req carries one request per transaction: opcode 0 allocates a slot,
// opcode 1 returns the handle given by free_chunk and free_slot.
// out_rsp returns exactly one result per request, in request order:
// status, chunk, slot and byte_offset (slot times element size).
// cfg_wr_en/cfg_wr_data load the element size; write it only while idle.
// The result is buffered when its request is taken. Throughput: one
// request per cycle while the buffer has room; the head register and the
// LIFO store behind it are updated in the accepting cycle, and the store
// RAM read for the next pop is prefetched with a one-entry write bypass.
// A two-entry result buffer decouples the sides; in_req.ready drops only
// when both entries hold results the receiver has not taken, so a stalled
// receiver holds at most two results and then stops intake.
// Reset (synchronous, rst_n low) empties the free list, rewinds to slot 0
// of chunk 0, sets the element size to 1 and drops all buffered results.
// The store RAM needs no clearing; its entries are read only once written.
`default_nettype none
module fixed_slot_pool_allocator import fspa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [ESIZE_W-1:0] cfg_wr_data,
  fspa_req_if.sink                in_req,
  fspa_rsp_if.source              out_rsp
);

  core_out_t core_out;
  logic      out_room;

  fspa_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_room (out_room),
    .core_out (core_out)
  );

  fspa_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .core_out    (core_out),
    .out_room    (out_room),
    .out_rsp     (out_rsp)
  );

endmodule
`default_nettype wire

### sv/fspa_checker.sv
// Port-level checker for the fixed slot pool allocator and its bind
`default_nettype none
`include "assert_macros.svh"
module fspa_checker import fspa_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                cfg_wr_en,
  input wire logic [ESIZE_W-1:0]  cfg_wr_data,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [1:0]          out_status,
  input wire logic [CHUNK_W-1:0]  out_chunk,
  input wire logic [SLOT_W-1:0]   out_slot,
  input wire logic [OFFSET_W-1:0] out_byte_offset
);

  logic [ESIZE_W-1:0] esize_r;
  logic [1:0]         pend_r, pend_nxt;
  logic               in_acc;
  logic               out_acc;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esize_r <= ESIZE_RESET;
      pend_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        esize_r <= cfg_wr_data;
      end
      pend_r <= pend_nxt;
    end
  end

  `CHK_SAME(a_no_spurious_result, clk, rst_n, out_valid, pend_r != 2'd0, "result without request")
  `CHK_SAME(a_error_fields_zero, clk, rst_n, out_valid && (out_status != ST_OK), (out_chunk == '0) && (out_slot == '0) && (out_byte_offset == '0), "error result with nonzero fields")
  `CHK_SAME(a_offset_product, clk, rst_n, out_valid, out_byte_offset == (OFFSET_W'(out_slot) * OFFSET_W'(esize_r)), "byte offset mismatch")
  `CHK_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_status, out_chunk, out_slot, out_byte_offset}), "stalled result changed")

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_wr_en       (cfg_wr_en),
  .cfg_wr_data     (cfg_wr_data),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_status      (out_rsp.status),
  .out_chunk       (out_rsp.chunk),
  .out_slot        (out_rsp.slot),
  .out_byte_offset (out_rsp.byte_offset)
);
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of fixed_slot_pool_allocator: random alloc/free traffic vs a free-list model
module tb_top;
  import fspa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 33;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AT     = 400;

  typedef struct packed {
    opcode_t            op;
    logic [CHUNK_W-1:0] chunk;
    logic [SLOT_W-1:0]  slot;
  } pool_req_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [ESIZE_W-1:0] cfg_wr_data;

  fspa_req_if req_bus ();
  fspa_rsp_if rsp_bus ();

  fixed_slot_pool_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_req     (req_bus),
    .out_rsp    (rsp_bus)
  );

  // Pool model state
  logic [ESIZE_W-1:0]  m_esize = ESIZE_RESET;
  int                  m_chunk = 0;
  int                  m_cursor = 0;
  logic                m_head_valid = 1'b0;
  logic [HANDLE_W-1:0] m_head = '0;
  logic [HANDLE_W-1:0] m_stack [FREE_DEPTH];
  int                  m_depth = 0;

  pool_req_t pending_reqs [$];
  rsp_t      expected_grants [$];
  int        sent_cnt = 0;
  int        rsp_cnt = 0;
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  logic      req_fire = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic rsp_t predict_grant(pool_req_t r);
    rsp_t                res;
    logic [HANDLE_W-1:0] h;
    int                  cap;
    res = '0;
    res.base.status = ST_OK;
    if (r.op == OP_FREE) begin
      h = {r.chunk, r.slot};
      if (!m_head_valid) begin
        m_head = h;
        m_head_valid = 1'b1;
      end else if (m_depth < FREE_DEPTH) begin
        m_stack[m_depth] = h;
        m_depth++;
      end else begin
        res.base.status = ST_STORE_FULL;
      end
    end else if (m_head_valid) begin
      h = m_head;
      if (m_depth > 0) begin
        m_depth--;
        m_head = m_stack[m_depth];
      end else begin
        m_head_valid = 1'b0;
      end
      res.base.chunk = h[HANDLE_W-1:SLOT_W];
      res.base.slot  = h[SLOT_W-1:0];
    end else begin
      cap = (m_chunk == 0) ? CHUNK_CAP0 : CHUNK_CAPN;
      if (m_cursor >= cap && m_chunk + 1 >= MAX_CHUNKS) begin
        res.base.status = ST_NO_CHUNK;
      end else begin
        if (m_cursor >= cap) begin
          m_chunk++;
          m_cursor = 0;
        end
        res.base.chunk = CHUNK_W'(m_chunk);
        res.base.slot  = SLOT_W'(m_cursor);
        m_cursor++;
      end
    end
    res.byte_offset = OFFSET_W'(int'(res.base.slot) * int'(m_esize));
    return res;
  endfunction

  function automatic bit quiet_window();
    return sent_cnt >= 1200 && sent_cnt < 1600;
  endfunction

  task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("ERROR result %0d %s: expected %0d, got %0d", rsp_cnt, field, want, got);
  endtask

  // Request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else if (req_bus.valid && !req_fire) begin
      // hold the offered transaction
    end else if (pending_reqs.size() > 0 &&
                 (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= pending_reqs[0].op;
      req_bus.free_chunk <= pending_reqs[0].chunk;
      req_bus.free_slot  <= pending_reqs[0].slot;
    end else begin
      req_bus.valid <= 1'b0;
    end
  end

  // Result ready, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      rsp_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      rsp_bus.ready <= quiet_window() || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    rsp_t want;
    req_fire <= rst_n && req_bus.valid && req_bus.ready;
    if (rst_n && req_bus.valid && req_bus.ready) begin
      expected_grants.push_back(predict_grant(pending_reqs.pop_front()));
      sent_cnt++;
    end
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_grants.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("ERROR result %0d arrived with no request outstanding", rsp_cnt);
      end else begin
        want = expected_grants.pop_front();
        if (rsp_bus.status !== want.base.status)
          flag_mismatch("status", want.base.status, rsp_bus.status);
        if (rsp_bus.chunk !== want.base.chunk)
          flag_mismatch("chunk", want.base.chunk, rsp_bus.chunk);
        if (rsp_bus.slot !== want.base.slot)
          flag_mismatch("slot", want.base.slot, rsp_bus.slot);
        if (rsp_bus.byte_offset !== want.byte_offset)
          flag_mismatch("byte_offset", want.byte_offset, rsp_bus.byte_offset);
      end
      rsp_cnt++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_alloc();
    pool_req_t r;
    r = '{op: OP_ALLOC, chunk: '0, slot: '0};
    pending_reqs.push_back(r);
  endtask

  task automatic push_free(int c, int s);
    pool_req_t r;
    r = '{op: OP_FREE, chunk: CHUNK_W'(c), slot: SLOT_W'(s)};
    pending_reqs.push_back(r);
  endtask

  task automatic push_random_free();
    push_free($urandom_range(0, (1 << CHUNK_W) - 1), $urandom_range(0, (1 << SLOT_W) - 1));
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_grants.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_esize(logic [ESIZE_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    m_esize = v;
  endtask

  initial begin
    int seg;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_bus.valid      = 1'b0;
    req_bus.opcode     = OP_ALLOC;
    req_bus.free_chunk = '0;
    req_bus.free_slot  = '0;
    rsp_bus.ready      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fresh slots, head and LIFO order, double return, extremes
    push_alloc();
    push_alloc();
    push_free(15, 127);
    push_free(0, 0);
    push_free(15, 127);
    push_alloc();
    push_alloc();
    push_alloc();
    push_alloc();

    set_esize(16'hFFFF);
    push_free(10, 85);
    push_free(5, 42);
    push_alloc();
    push_alloc();
    push_alloc();
    push_free(15, 127);
    push_alloc();

    // Fill the free store past its depth, then pop part of it with zero element size
    set_esize('0);
    repeat (FREE_DEPTH + 6) push_random_free();
    repeat (20) push_alloc();

    // Mostly allocations, element size swept per segment
    seg = 0;
    while (seg < 5) begin
      case (seg % 5)
        0: set_esize(16'd1);
        1: set_esize(16'hFFFF);
        2: set_esize('0);
        default: set_esize(ESIZE_W'($urandom_range(2, 65534)));
      endcase
      repeat (320) begin
        if ($urandom_range(0, 99) < 92)
          push_alloc();
        else
          push_random_free();
      end
      seg++;
    end

    // Mixed returns and allocations
    set_esize(ESIZE_W'($urandom_range(1, 65535)));
    repeat (60) begin
      if ($urandom_range(0, 1) == 0)
        push_alloc();
      else
        push_random_free();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/fspa_pkg.sv
sv/fspa_req_if.sv
sv/fspa_rsp_if.sv
sv/fspa_ram.sv
sv/fspa_core.sv
sv/fspa_out.sv
sv/fixed_slot_pool_allocator.sv
sv/fspa_checker.sv
tb/tb_top.sv
